FILE: rtl/core/template_match_argmax_core_macros.svh
// Assertion macros for the template match core's sequencer.
// Each check samples on clk and is disabled while rst_n is low.
`ifndef TEMPLATE_MATCH_ARGMAX_CORE_MACROS_SVH
`define TEMPLATE_MATCH_ARGMAX_CORE_MACROS_SVH

`ifndef SYNTH

`define TMAM_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tmam: same-cycle check failed");

`define TMAM_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tmam: next-cycle check failed");

`else

`define TMAM_ASSERT_IMP(name, ante, cons)

`define TMAM_ASSERT_NEXT(name, ante, cons)

`endif

`endif

FILE: rtl/core/tmam_pkg.sv
`default_nettype none

package tmam_pkg;

    localparam int IMAGE_MAX   = 64;
    localparam int FEATURE_MAX = 16;
    localparam int SAMPLE_BITS = 8;

    localparam int IMG_DEPTH  = IMAGE_MAX * IMAGE_MAX;
    localparam int FEAT_DEPTH = FEATURE_MAX * FEATURE_MAX;
    localparam int IMG_AW     = (IMG_DEPTH > 1) ? $clog2(IMG_DEPTH) : 1;
    localparam int FEAT_AW    = (FEAT_DEPTH > 1) ? $clog2(FEAT_DEPTH) : 1;
    localparam int POS_W      = (IMAGE_MAX > 1) ? $clog2(IMAGE_MAX) : 1;
    localparam int TAP_W      = (FEATURE_MAX > 1) ? $clog2(FEATURE_MAX) : 1;

    // Field and register widths fixed by the interface
    localparam int CMD_W    = 2;
    localparam int INDEX_W  = 12;
    localparam int VALUE_W  = 8;
    localparam int OUT_POS_W = 6;
    localparam int SCORE_W  = 24;
    localparam int NSIDE_W  = 7;
    localparam int FSIDE_W  = 5;

    localparam int PROD_W = 2 * SAMPLE_BITS;
    localparam int ACC_W  = PROD_W + 2 * TAP_W + 1;

    localparam logic signed [ACC_W-1:0] SCORE_HI = ACC_W'((64'sd1 <<< (SCORE_W - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SCORE_LO = ACC_W'(-(64'sd1 <<< (SCORE_W - 1)));
    localparam logic signed [SCORE_W-1:0] SCORE_INIT = -SCORE_W'(1);

    localparam logic [INDEX_W:0] IMG_DEPTH_X  = (INDEX_W+1)'(IMG_DEPTH);
    localparam logic [INDEX_W:0] FEAT_DEPTH_X = (INDEX_W+1)'(FEAT_DEPTH);

    localparam logic [NSIDE_W-1:0] IMAGE_SIDE_RESET   = NSIDE_W'(64);
    localparam logic [FSIDE_W-1:0] FEATURE_SIDE_RESET = FSIDE_W'(16);

    // Commands carried on tuser
    localparam logic [CMD_W-1:0] CMD_LOAD_FEAT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_IMG  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RUN       = 2'd2;

    // Register select, paddr bit 2
    localparam logic REG_IMAGE_SIDE   = 1'b0;
    localparam logic REG_FEATURE_SIDE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DELIVER
    } seq_state_t;

    typedef struct packed {
        logic             valid;
        logic             last_tap;
        logic             last_off;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
    } tap_tag_t;

    typedef struct packed {
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic signed [SCORE_W-1:0] score;
    } best_t;

    function automatic logic [NSIDE_W-1:0] clamp_image_side(input logic [NSIDE_W-1:0] s);
        logic [NSIDE_W-1:0] r;
        if (s == '0)
            r = NSIDE_W'(1);
        else if (s > NSIDE_W'(IMAGE_MAX))
            r = NSIDE_W'(IMAGE_MAX);
        else
            r = s;
        return r;
    endfunction

    function automatic logic [FSIDE_W-1:0] clamp_feature_side(input logic [FSIDE_W-1:0] s);
        logic [FSIDE_W-1:0] r;
        if (s == '0)
            r = FSIDE_W'(1);
        else if (s > FSIDE_W'(FEATURE_MAX))
            r = FSIDE_W'(FEATURE_MAX);
        else
            r = s;
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/tmam_store.sv
`default_nettype none

module tmam_store
    import tmam_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   img_we,
    input  wire logic [IMG_AW-1:0]      img_waddr,
    input  wire logic                   feat_we,
    input  wire logic [FEAT_AW-1:0]     feat_waddr,
    input  wire logic [SAMPLE_BITS-1:0] wdata,
    input  wire logic [IMG_AW-1:0]      img_raddr,
    input  wire logic [FEAT_AW-1:0]     feat_raddr,
    output logic      [SAMPLE_BITS-1:0] img_rdata,
    output logic      [SAMPLE_BITS-1:0] feat_rdata
);

    logic [SAMPLE_BITS-1:0] img_mem  [IMG_DEPTH];
    logic [SAMPLE_BITS-1:0] feat_mem [FEAT_DEPTH];

    always_ff @(posedge clk)
    begin
        if (img_we)
        begin
            img_mem[img_waddr] <= wdata;
        end
        img_rdata <= img_mem[img_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (feat_we)
        begin
            feat_mem[feat_waddr] <= wdata;
        end
        feat_rdata <= feat_mem[feat_raddr];
    end

endmodule

`default_nettype wire

FILE: rtl/core/tmam_seq.sv
`default_nettype none

`include "template_match_argmax_core_macros.svh"

module tmam_seq
    import tmam_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [NSIDE_W-1:0] n_side,
    input  wire logic [FSIDE_W-1:0] f_side,
    input  wire logic               done,
    input  wire logic               out_free,
    output logic                    idle,
    output logic                    deliver,
    output tap_tag_t                tag,
    output logic      [IMG_AW-1:0]  img_raddr,
    output logic      [FEAT_AW-1:0] feat_raddr
);

    seq_state_t state_reg, state_next;

    logic [POS_W-1:0]   r_reg, r_next, c_reg, c_next;
    logic [TAP_W-1:0]   a_reg, a_next, b_reg, b_next;
    logic [IMG_AW-1:0]  org_row_reg, org_row_next;   // r*n
    logic [IMG_AW-1:0]  org_reg, org_next;           // r*n + c
    logic [IMG_AW-1:0]  row_ptr_reg, row_ptr_next;   // (r+a)*n + c
    logic [IMG_AW-1:0]  img_addr_reg, img_addr_next;
    logic [FEAT_AW-1:0] feat_addr_reg, feat_addr_next;

    logic [TAP_W-1:0]  f_m1;
    logic [POS_W-1:0]  span_m1;
    logic [IMG_AW-1:0] n_step;
    logic              last_b, last_a, last_c, last_r, last_tap, last_off, too_big;

    assign f_m1    = TAP_W'(f_side - FSIDE_W'(1));
    assign span_m1 = POS_W'(n_side - NSIDE_W'(f_side));
    assign n_step  = IMG_AW'(n_side);
    assign too_big = NSIDE_W'(f_side) > n_side;

    assign last_b   = b_reg == f_m1;
    assign last_a   = a_reg == f_m1;
    assign last_c   = c_reg == span_m1;
    assign last_r   = r_reg == span_m1;
    assign last_tap = last_a && last_b;
    assign last_off = last_tap && last_c && last_r;

    // Counter and address walk: taps inside an offset, offsets row by row
    always_comb
    begin
        r_next         = r_reg;
        c_next         = c_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        org_row_next   = org_row_reg;
        org_next       = org_reg;
        row_ptr_next   = row_ptr_reg;
        img_addr_next  = img_addr_reg;
        feat_addr_next = feat_addr_reg;
        if (state_reg != ST_RUN)
        begin
            r_next         = '0;
            c_next         = '0;
            a_next         = '0;
            b_next         = '0;
            org_row_next   = '0;
            org_next       = '0;
            row_ptr_next   = '0;
            img_addr_next  = '0;
            feat_addr_next = '0;
        end
        else if (!last_b)
        begin
            b_next         = b_reg + TAP_W'(1);
            img_addr_next  = img_addr_reg + IMG_AW'(1);
            feat_addr_next = feat_addr_reg + FEAT_AW'(1);
        end
        else if (!last_a)
        begin
            b_next         = '0;
            a_next         = a_reg + TAP_W'(1);
            row_ptr_next   = row_ptr_reg + n_step;
            img_addr_next  = row_ptr_reg + n_step;
            feat_addr_next = feat_addr_reg + FEAT_AW'(1);
        end
        else
        begin
            a_next         = '0;
            b_next         = '0;
            feat_addr_next = '0;
            if (!last_c)
            begin
                c_next        = c_reg + POS_W'(1);
                org_next      = org_reg + IMG_AW'(1);
                row_ptr_next  = org_reg + IMG_AW'(1);
                img_addr_next = org_reg + IMG_AW'(1);
            end
            else if (!last_r)
            begin
                c_next        = '0;
                r_next        = r_reg + POS_W'(1);
                org_row_next  = org_row_reg + n_step;
                org_next      = org_row_reg + n_step;
                row_ptr_next  = org_row_reg + n_step;
                img_addr_next = org_row_reg + n_step;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = too_big ? ST_DELIVER : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (last_off)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (done)
                begin
                    state_next = ST_DELIVER;
                end
            end
            ST_DELIVER:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        idle          = state_reg == ST_IDLE;
        deliver       = (state_reg == ST_DELIVER) && out_free;
        tag.valid     = state_reg == ST_RUN;
        tag.last_tap  = last_tap;
        tag.last_off  = last_off;
        tag.row       = r_reg;
        tag.col       = c_reg;
        img_raddr     = img_addr_reg;
        feat_raddr    = feat_addr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            r_reg         <= '0;
            c_reg         <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            org_row_reg   <= '0;
            org_reg       <= '0;
            row_ptr_reg   <= '0;
            img_addr_reg  <= '0;
            feat_addr_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            r_reg         <= r_next;
            c_reg         <= c_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            org_row_reg   <= org_row_next;
            org_reg       <= org_next;
            row_ptr_reg   <= row_ptr_next;
            img_addr_reg  <= img_addr_next;
            feat_addr_reg <= feat_addr_next;
        end
    end

    `TMAM_ASSERT_IMP(a_done_only_in_drain, done, state_reg == ST_DRAIN)
    `TMAM_ASSERT_IMP(a_tap_in_range, tag.valid, (a_reg <= f_m1) && (b_reg <= f_m1))
    `TMAM_ASSERT_NEXT(a_deliver_then_idle, deliver, state_reg == ST_IDLE)

endmodule

`default_nettype wire

FILE: rtl/core/tmam_mac.sv
`default_nettype none

module tmam_mac
    import tmam_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire tap_tag_t               tag,
    input  wire logic [SAMPLE_BITS-1:0] img_rdata,
    input  wire logic [SAMPLE_BITS-1:0] feat_rdata,
    output logic                        done,
    output best_t                       best
);

    tap_tag_t tag_d1_reg, tag_d2_reg, tag_d3_reg;

    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic signed [ACC_W-1:0]   sum;
    logic signed [SCORE_W-1:0] score_reg, score_sat;
    best_t                     best_reg, best_next;
    logic                      done_reg;

    logic [POS_W:0] rc_new, rc_best;
    logic           take;

    // Accumulate one product per cycle; close the offset on its last tap
    always_comb
    begin
        sum = acc_reg + ACC_W'(prod_reg);
        if (sum > SCORE_HI)
            score_sat = SCORE_W'(SCORE_HI);
        else if (sum < SCORE_LO)
            score_sat = SCORE_W'(SCORE_LO);
        else
            score_sat = SCORE_W'(sum);
        acc_next = acc_reg;
        if (start)
            acc_next = '0;
        else if (tag_d2_reg.valid)
            acc_next = tag_d2_reg.last_tap ? '0 : sum;
    end

    // Larger score wins; on a tie, the smaller row+col wins
    always_comb
    begin
        rc_new  = {1'b0, tag_d3_reg.row} + {1'b0, tag_d3_reg.col};
        rc_best = {1'b0, best_reg.row} + {1'b0, best_reg.col};
        take    = (score_reg > best_reg.score) ||
                  ((score_reg == best_reg.score) && (rc_new < rc_best));
        best_next = best_reg;
        if (start)
        begin
            best_next.row   = '0;
            best_next.col   = '0;
            best_next.score = SCORE_INIT;
        end
        else if (tag_d3_reg.valid && take)
        begin
            best_next.row   = tag_d3_reg.row;
            best_next.col   = tag_d3_reg.col;
            best_next.score = score_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= $signed(img_rdata) * $signed(feat_rdata);
        if (tag_d2_reg.valid && tag_d2_reg.last_tap)
        begin
            score_reg <= score_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_d1_reg <= '0;
            tag_d2_reg <= '0;
            tag_d3_reg <= '0;
            acc_reg    <= '0;
            best_reg   <= '{row: '0, col: '0, score: SCORE_INIT};
            done_reg   <= 1'b0;
        end
        else
        begin
            tag_d1_reg <= tag;
            tag_d2_reg <= tag_d1_reg;
            tag_d3_reg <= '{valid:    tag_d2_reg.valid && tag_d2_reg.last_tap,
                            last_tap: tag_d2_reg.last_tap,
                            last_off: tag_d2_reg.last_off,
                            row:      tag_d2_reg.row,
                            col:      tag_d2_reg.col};
            acc_reg    <= acc_next;
            best_reg   <= best_next;
            done_reg   <= tag_d3_reg.valid && tag_d3_reg.last_off;
        end
    end

    assign done = done_reg;
    assign best = best_reg;

endmodule

`default_nettype wire

FILE: rtl/core/template_match_argmax_core.sv
// Template match core: square cross-correlation with best-offset search.
// Input stream (s_*): tuser carries the command, tdata the index and value.
//   Load feature / load image each write one element into its store;
//   they give no output transaction. Run walks every offset at which the
//   feature fits inside the image and returns one output transaction with
//   the best row, column and score.
// Config port: APB-style, image_side at 0x0, feature_side at 0x4; write
//   only while the core is idle.
// Throughput: one multiply-accumulate per cycle through a single shared
//   multiplier. s_tready stays low for the whole run.
// Output: the result is held in an output register; loads keep flowing
//   while it waits. A following run finishes its walk but holds its result
//   until the receiver takes the previous one.
// Reset: side registers go to 64 and 16, the output register empties. Both
//   element stores keep no reset; load them before a run reads them.
`default_nettype none

module template_match_argmax_core
    import tmam_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // APB-style config
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // index[11:0], value[19:12], zero[23:20]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata    // best_row[5:0], best_col[11:6],
                                        // best_score[35:12], zero[39:36]
);

    logic [NSIDE_W-1:0] image_side_reg;
    logic [FSIDE_W-1:0] feature_side_reg;
    logic [NSIDE_W-1:0] n_side;
    logic [FSIDE_W-1:0] f_side;
    logic               cfg_write;

    logic [INDEX_W-1:0]     in_index;
    logic [VALUE_W-1:0]     in_value;
    logic [CMD_W-1:0]       in_cmd;
    logic                   s_accept;
    logic                   run_start;
    logic                   img_we, feat_we;

    logic                   idle, deliver, done, out_free;
    tap_tag_t               tag;
    logic [IMG_AW-1:0]      img_raddr;
    logic [FEAT_AW-1:0]     feat_raddr;
    logic [SAMPLE_BITS-1:0] img_rdata, feat_rdata;
    best_t                  best;

    logic                   m_tvalid_reg, m_tvalid_next;
    logic [39:0]            m_tdata_reg;

    // Config registers: written on the access phase; pready is tied high
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_side_reg   <= IMAGE_SIDE_RESET;
            feature_side_reg <= FEATURE_SIDE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_IMAGE_SIDE)
                image_side_reg <= pwdata[NSIDE_W-1:0];
            else
                feature_side_reg <= pwdata[FSIDE_W-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == REG_FEATURE_SIDE)
            prdata = 32'(feature_side_reg);
        else
            prdata = 32'(image_side_reg);
    end

    // Sides in use, saturated to the legal range
    assign n_side = clamp_image_side(image_side_reg);
    assign f_side = clamp_feature_side(feature_side_reg);

    // Unpack the input transaction
    assign in_index = s_tdata[INDEX_W-1:0];
    assign in_value = s_tdata[INDEX_W +: VALUE_W];
    assign in_cmd   = s_tuser;

    // Accept only between runs; a load out of range is dropped
    assign s_tready  = idle;
    assign s_accept  = s_tvalid && s_tready;
    assign run_start = s_accept && (in_cmd == CMD_RUN);
    assign img_we    = s_accept && (in_cmd == CMD_LOAD_IMG) &&
                       ({1'b0, in_index} < IMG_DEPTH_X);
    assign feat_we   = s_accept && (in_cmd == CMD_LOAD_FEAT) &&
                       ({1'b0, in_index} < FEAT_DEPTH_X);

    tmam_store u_store (
        .clk        (clk),
        .img_we     (img_we),
        .img_waddr  (in_index[IMG_AW-1:0]),
        .feat_we    (feat_we),
        .feat_waddr (in_index[FEAT_AW-1:0]),
        .wdata      (in_value[SAMPLE_BITS-1:0]),
        .img_raddr  (img_raddr),
        .feat_raddr (feat_raddr),
        .img_rdata  (img_rdata),
        .feat_rdata (feat_rdata)
    );

    tmam_seq u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (run_start),
        .n_side     (n_side),
        .f_side     (f_side),
        .done       (done),
        .out_free   (out_free),
        .idle       (idle),
        .deliver    (deliver),
        .tag        (tag),
        .img_raddr  (img_raddr),
        .feat_raddr (feat_raddr)
    );

    tmam_mac u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (run_start),
        .tag        (tag),
        .img_rdata  (img_rdata),
        .feat_rdata (feat_rdata),
        .done       (done),
        .best       (best)
    );

    // Output register: free when empty or being taken this cycle
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (deliver)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else
            m_tvalid_reg <= m_tvalid_next;
    end

    always_ff @(posedge clk)
    begin
        if (deliver)
        begin
            m_tdata_reg <= {4'b0000, best.score,
                            OUT_POS_W'(best.col), OUT_POS_W'(best.row)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`default_nettype none

module tb;
    import tmam_pkg::*;

    // Unused command code: the core must swallow it without a result
    localparam logic [CMD_W-1:0] CMD_NONE = 2'd3;

    localparam int RANDOM_ITEMS  = 1250;
    localparam int LONG_HOLD     = 3000;     // one long receiver hold-off, in cycles
    localparam int STALL_LIMIT   = 100000;   // cycles with no transaction before giving up
    localparam int SETTLE_CYCLES = 10;       // quiet cycles before a register write

    // One input element command as it travels on tuser/tdata
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [INDEX_W-1:0] index;
        logic [VALUE_W-1:0] value;
    } elem_cmd_t;

    // One match result as it travels on m_tdata
    typedef struct packed {
        logic [OUT_POS_W-1:0]      row;
        logic [OUT_POS_W-1:0]      col;
        logic signed [SCORE_W-1:0] score;
    } match_t;

    // Clock, reset and every block input start at known values
    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic        s_tvalid = 1'b0;
    logic [23:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        m_tready = 1'b0;

    logic [31:0] prdata;
    logic        pready;
    logic        s_tready;
    logic        m_tvalid;
    logic [39:0] m_tdata;

    // Predictor copy of the element stores and the side registers
    logic signed [VALUE_W-1:0] img_mem  [IMG_DEPTH];
    logic signed [VALUE_W-1:0] feat_mem [FEAT_DEPTH];
    logic [NSIDE_W-1:0]        img_side_cfg  = IMAGE_SIDE_RESET;
    logic [FSIDE_W-1:0]        feat_side_cfg = FEATURE_SIDE_RESET;

    // Stimulus side: which store entries will have been written by the time
    // the queued commands are taken, so a run never reads an unwritten entry
    bit        img_loaded  [IMG_DEPTH];
    bit        feat_loaded [FEAT_DEPTH];
    elem_cmd_t elem_q [$];
    match_t    best_q [$];

    int queued_cnt  = 0;   // commands pushed to elem_q
    int useful_cnt  = 0;   // commands the core actually acts on
    int sent_cnt    = 0;   // commands put on the input bus
    int acc_cnt     = 0;   // input transactions accepted
    int run_cnt     = 0;
    int chk_cnt     = 0;
    int cfg_writes  = 0;
    int err_cnt     = 0;
    int quiet_cycles = 0;

    // Sender burst shaping
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall pattern and the one long hold-off
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int hold_cnt  = 0;
    int rx_mode   = 0;
    int rx_left   = 0;
    int rx_phase  = 0;

    template_match_argmax_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // index[11:0], value[19:12], zero[23:20]
        .s_tuser  (s_tuser),    // command[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // best_row[5:0], best_col[11:6], best_score[35:12], zero[39:36]
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate a side register value into the range the core can use
    function automatic int side_in_use(input int s, input int hi);
        if (s < 1)
            return 1;
        if (s > hi)
            return hi;
        return s;
    endfunction

    // Slide the feature over every offset that fits and keep the best score;
    // ties go to the offset closer to the origin (smaller row plus column)
    function automatic match_t best_offset();
        int     n;
        int     f;
        int     span;
        int     sum;
        int     best_sum;
        int     best_r;
        int     best_c;
        match_t res;
        n        = side_in_use(int'(img_side_cfg), IMAGE_MAX);
        f        = side_in_use(int'(feat_side_cfg), FEATURE_MAX);
        best_sum = -1;
        best_r   = 0;
        best_c   = 0;
        if (f <= n)
        begin
            span = n - f + 1;
            for (int r = 0; r < span; r++)
            begin
                for (int c = 0; c < span; c++)
                begin
                    sum = 0;
                    for (int a = 0; a < f; a++)
                    begin
                        for (int b = 0; b < f; b++)
                        begin
                            sum += int'(img_mem[(r + a) * n + c + b]) * int'(feat_mem[a * f + b]);
                        end
                    end
                    // clip each offset's sum to the score width before comparing
                    if (sum > 8388607)
                        sum = 8388607;
                    if (sum < -8388608)
                        sum = -8388608;
                    if (sum > best_sum)
                    begin
                        best_sum = sum;
                        best_r   = r;
                        best_c   = c;
                    end
                    else if (sum == best_sum && r + c < best_r + best_c)
                    begin
                        best_r = r;
                        best_c = c;
                    end
                end
            end
        end
        res.row   = OUT_POS_W'(best_r);
        res.col   = OUT_POS_W'(best_c);
        res.score = SCORE_W'(best_sum);
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Queue one command and track which store entries it will write
    function automatic void queue_cmd(input logic [CMD_W-1:0] cmd, input int idx, input int val);
        elem_cmd_t it;
        it.cmd   = cmd;
        it.index = INDEX_W'(idx);
        it.value = VALUE_W'(val);
        elem_q.push_back(it);
        queued_cnt++;
        if (cmd == CMD_LOAD_IMG)
        begin
            img_loaded[idx] = 1'b1;
            useful_cnt++;
        end
        else if (cmd == CMD_LOAD_FEAT && idx < FEAT_DEPTH)
        begin
            feat_loaded[idx] = 1'b1;
            useful_cnt++;
        end
        else if (cmd == CMD_RUN)
            useful_cnt++;
    endfunction

    // Element values: full range, a narrow band around zero that breeds ties,
    // negatives only, or the sign extremes
    function automatic int pick_value(input int mode);
        case (mode)
            0: return int'($urandom_range(0, 255)) - 128;
            1: return int'($urandom_range(0, 4)) - 2;
            2: return -int'($urandom_range(1, 128));
            default:
                case ($urandom_range(0, 3))
                    0: return -128;
                    1: return 127;
                    2: return 0;
                    default: return -1;
                endcase
        endcase
    endfunction

    // Load every entry a run at these sides will read that is still unwritten
    function automatic void fill_needed(input int n, input int f, input int mode);
        if (f > n)
            return;
        for (int i = 0; i < n * n; i++)
        begin
            if (!img_loaded[i])
                queue_cmd(CMD_LOAD_IMG, i, pick_value(mode));
        end
        for (int i = 0; i < f * f; i++)
        begin
            if (!feat_loaded[i])
                queue_cmd(CMD_LOAD_FEAT, i, pick_value(mode));
        end
    endfunction

    function automatic void queue_run();
        queue_cmd(CMD_RUN, int'($urandom_range(0, 4095)), int'($urandom_range(0, 255)));
    endfunction

    // Write one side register over the config port: setup, then access
    task automatic write_side_reg(input logic sel, input int val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= 32'(val);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (sel == REG_IMAGE_SIDE)
            img_side_cfg = NSIDE_W'(val);
        else
            feat_side_cfg = FSIDE_W'(val);
        cfg_writes++;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Hold the sender until every queued command is taken and every result is
    // back, then let the last load settle so the core is idle
    task automatic wait_drained();
        while (acc_cnt != queued_cnt || best_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // One random setting: a few loads between runs, random content
    task automatic random_phase();
        int n;
        int f;
        int mode;
        int sel;
        if ($urandom_range(0, 19) == 0)
        begin
            // feature wider than the image: nothing fits
            n = $urandom_range(1, 8);
            f = $urandom_range(n + 1, 16);
        end
        else
        begin
            n = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 12);
            f = $urandom_range(1, (n < 6) ? n : 6);
        end
        write_side_reg(REG_IMAGE_SIDE, n);
        write_side_reg(REG_FEATURE_SIDE, f);
        mode = $urandom_range(0, 3);
        fill_needed(n, f, mode);
        repeat ($urandom_range(2, 7))
        begin
            repeat ($urandom_range(0, 6))
            begin
                sel = $urandom_range(0, 19);
                if (sel < 14)
                    queue_cmd(CMD_LOAD_IMG, $urandom_range(0, n * n - 1), pick_value(mode));
                else if (sel < 15)
                    queue_cmd(CMD_LOAD_IMG, $urandom_range(0, IMG_DEPTH - 1), pick_value(mode));
                else if (sel < 19)
                    queue_cmd(CMD_LOAD_FEAT, $urandom_range(0, f * f - 1), pick_value(mode));
                else
                    queue_cmd(CMD_LOAD_FEAT, $urandom_range(0, 4095), pick_value(mode));
            end
            if ($urandom_range(0, 19) == 0)
                queue_cmd(CMD_NONE, $urandom_range(0, 4095), $urandom_range(0, 255));
            queue_run();
        end
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Input driver: advance on acceptance, work in bursts with random gaps
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : elem_driver
        elem_cmd_t it;
        // the slot is free when nothing is offered or the last offer was taken
        if (!s_tvalid || acc_cnt == sent_cnt)
        begin
            if (gap_left != 0)
            begin
                gap_left--;
                s_tvalid <= 1'b0;
            end
            else if (elem_q.size() != 0)
            begin
                it = elem_q.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.cmd;
                s_tdata  <= {4'b0000, it.value, it.index};
                sent_cnt++;
                if (burst_left == 0)
                begin
                    // open a new burst; about a quarter of them follow with no gap
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
                end
                else
                    burst_left--;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Input monitor: apply each accepted transaction to the predictor
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            acc_cnt++;
            case (s_tuser)
                CMD_LOAD_FEAT:
                    if (s_tdata[11:0] < FEAT_DEPTH)
                        feat_mem[s_tdata[FEAT_AW-1:0]] = s_tdata[19:12];
                CMD_LOAD_IMG:
                    img_mem[s_tdata[11:0]] = s_tdata[19:12];
                CMD_RUN:
                begin
                    best_q.push_back(best_offset());
                    run_cnt++;
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall on a pattern of its own, plus one long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (hold_req && !hold_done)
        begin
            // hold off long enough for a second run to finish and back up the input
            hold_cnt++;
            if (hold_cnt >= LONG_HOLD)
                hold_done = 1'b1;
            m_tready <= 1'b0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            else
                rx_left--;
            rx_phase++;
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= (rx_phase % 5 != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        match_t got;
        match_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.row   = m_tdata[OUT_POS_W-1:0];
            got.col   = m_tdata[2*OUT_POS_W-1:OUT_POS_W];
            got.score = m_tdata[2*OUT_POS_W+SCORE_W-1:2*OUT_POS_W];
            if (best_q.size() == 0)
            begin
                $error("unexpected result: row %0d col %0d score %0d",
                       got.row, got.col, got.score);
                err_cnt++;
            end
            else
            begin
                want = best_q.pop_front();
                chk_cnt++;
                if (got.row !== want.row)
                begin
                    $error("best_row mismatch: expected %0d, got %0d", want.row, got.row);
                    err_cnt++;
                end
                if (got.col !== want.col)
                begin
                    $error("best_col mismatch: expected %0d, got %0d", want.col, got.col);
                    err_cnt++;
                end
                if (got.score !== want.score)
                begin
                    $error("best_score mismatch: expected %0d, got %0d",
                           want.score, got.score);
                    err_cnt++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: drop the run when neither stream moves for too long
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int rand_start;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // 3x3 image, 1x1 feature. Equal peaks at (0,2) and (1,0): the later
        // one wins because it lies closer to the origin.
        write_side_reg(REG_IMAGE_SIDE, 3);
        write_side_reg(REG_FEATURE_SIDE, 1);
        queue_cmd(CMD_LOAD_FEAT, 0, 1);
        for (int i = 0; i < 9; i++)
            queue_cmd(CMD_LOAD_IMG, i, (i == 2 || i == 3) ? 7 : -5);
        queue_run();

        // every score negative: the result stays at the origin with -1
        queue_cmd(CMD_LOAD_IMG, 2, -5);
        queue_cmd(CMD_LOAD_IMG, 3, -5);
        queue_run();

        // most negative sample times most negative sample
        queue_cmd(CMD_LOAD_FEAT, 0, -128);
        queue_cmd(CMD_LOAD_IMG, 4, -128);
        queue_run();

        // unused command, feature load past the store, top image index
        queue_cmd(CMD_NONE, 4095, -1);
        queue_cmd(CMD_LOAD_FEAT, 4095, 127);
        queue_cmd(CMD_LOAD_IMG, 4095, 127);
        queue_run();
        wait_drained();

        // feature larger than the image
        write_side_reg(REG_IMAGE_SIDE, 2);
        write_side_reg(REG_FEATURE_SIDE, 3);
        queue_run();
        wait_drained();

        // zero in both side registers saturates to 1x1
        write_side_reg(REG_IMAGE_SIDE, 0);
        write_side_reg(REG_FEATURE_SIDE, 0);
        queue_run();
        wait_drained();

        // full feature, saturated from its top register value, one offset only
        write_side_reg(REG_IMAGE_SIDE, FEATURE_MAX);
        write_side_reg(REG_FEATURE_SIDE, 31);
        fill_needed(FEATURE_MAX, FEATURE_MAX, 0);
        queue_cmd(CMD_LOAD_FEAT, FEAT_DEPTH - 1, -128);
        queue_run();
        wait_drained();

        // receiver holds off while four runs queue up: one result waits in the
        // output register, the next in the core, and the input backs up
        hold_req = 1'b1;
        repeat (4)
            queue_run();
        wait_drained();

        // random settings
        rand_start = useful_cnt;
        while (useful_cnt - rand_start < RANDOM_ITEMS)
            random_phase();

        wait_drained();
        repeat (20) @(posedge clk);
        if (best_q.size() != 0)
        begin
            $error("%0d expected results never arrived", best_q.size());
            err_cnt++;
        end

        $display("Covered %0d input transactions including %0d match runs,",
                 acc_cnt, run_cnt);
        $display("over %0d register writes; checked %0d results, %0d mismatches.",
                 cfg_writes, chk_cnt, err_cnt);
        if (err_cnt == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire
